// ===== sv/assert_macros.svh =====
// assertion macros for the rtl, included by the top-level file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== sv/esds_pkg.sv =====
// types and constants of the descriptor config extractor
package esds_pkg;

  localparam int LEN_W    = 28;
  localparam int PHASE_W  = 4;
  localparam int SKIP_W   = 4;
  localparam int GRP_W    = 3;
  localparam int QDEPTH   = 3;
  localparam int QCNT_W   = 2;

  localparam logic [PHASE_W-1:0] PH_HDR  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_TAG1 = 4'd1;
  localparam logic [PHASE_W-1:0] PH_LEN1 = 4'd2;
  localparam logic [PHASE_W-1:0] PH_ID   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_PRIO = 4'd4;
  localparam logic [PHASE_W-1:0] PH_TAG2 = 4'd5;
  localparam logic [PHASE_W-1:0] PH_LEN2 = 4'd6;
  localparam logic [PHASE_W-1:0] PH_CFG  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_TAG3 = 4'd8;
  localparam logic [PHASE_W-1:0] PH_LEN3 = 4'd9;
  localparam logic [PHASE_W-1:0] PH_PAY  = 4'd10;
  localparam logic [PHASE_W-1:0] PH_DONE = 4'd11;

  localparam logic [SKIP_W-1:0] HDR_SKIP = 4'd4;
  localparam logic [SKIP_W-1:0] ID_SKIP  = 4'd2;
  localparam logic [SKIP_W-1:0] CFG_SKIP = 4'd13;

  localparam logic [7:0] TAG_ES_DESC   = 8'h03;
  localparam logic [7:0] TAG_DEC_CFG   = 8'h04;
  localparam logic [7:0] TAG_DEC_SPEC  = 8'h05;
  localparam logic [7:0] LEN_MORE_BIT  = 8'h80;
  localparam logic [7:0] LEN_GRP_MASK  = 8'h7f;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NONE      = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  typedef struct packed {
    logic             item_kind;
    logic [7:0]       payload_byte;
    logic [1:0]       status_code;
    logic [LEN_W-1:0] payload_length;
    logic             run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    item_a;
    result_t    item_b;
  } push_t;

endpackage

// ===== sv/esds_outq.sv =====
// three-entry result queue in front of the output stream
module esds_outq
  import esds_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_ready_i,
  output logic    valid_o,
  output result_t item_o,
  output logic    room_o
);

  logic [QCNT_W-1:0] cnt_q, cnt_d, cnt_mid;
  result_t           slot_q [QDEPTH];
  result_t           slot_d [QDEPTH];
  result_t           sh     [QDEPTH];
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[0];
  assign room_o  = !cnt_q[1];
  assign pop     = valid_o && pop_ready_i;
  assign cnt_mid = cnt_q - QCNT_W'(pop);
  assign cnt_d   = cnt_mid + push_i.cnt;

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) begin
        sh[i] = slot_q[i+1];
      end else begin
        sh[i] = slot_q[i];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (QCNT_W'(i) < cnt_mid) begin
        slot_d[i] = sh[i];
      end else if (QCNT_W'(i) == cnt_mid) begin
        slot_d[i] = push_i.item_a;
      end else begin
        slot_d[i] = push_i.item_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

// ===== sv/esds_decoder_config_extractor.sv =====
// top level: descriptor walker extracting decoder-specific config bytes
// results: the items of an accepted byte are registered into the result queue and leave from its head
// throughput: one byte per cycle while the queue has room; a record-end byte inside the payload yields two items
// input stalls while two or more items wait in the three-entry result queue
// reset: rst_ni clears the parse state to the header skip phase and empties the queue
`include "assert_macros.svh"

module esds_decoder_config_extractor
  import esds_pkg::*;
#(
  parameter int MAX_LENGTH_GROUPS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // record_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] payload_byte, [9:8] status_code,
                                        // [37:10] payload_length, [39:38] zero
  output logic        m_axis_tuser_o,   // item_kind
  output logic        m_axis_tlast_o    // run_last
);

  logic [PHASE_W-1:0] phase_q, phase_d, phase_s;
  logic [SKIP_W-1:0]  skip_q, skip_d, skip_s, skip_dec;
  logic [LEN_W-1:0]   acc_q, acc_d, acc_s, acc_shift;
  logic [GRP_W-1:0]   grp_q, grp_d, grp_s, grp_inc;
  logic [7:0]         tag_q, tag_d, tag_s;
  logic [LEN_W-1:0]   rem_q, rem_d, rem_s, rem_dec;
  logic               seen_q, seen_d, seen_s;
  logic               in_acc, len_done, pay_valid;
  logic [7:0]         b;
  result_t            pay_item, stat_item, out_item;
  push_t              push;
  logic               room;

  assign b        = s_axis_tdata_i;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign skip_dec = skip_q - SKIP_W'(1);
  assign rem_dec  = rem_q - LEN_W'(1);
  assign grp_inc  = grp_q + GRP_W'(1);
  assign acc_shift = {acc_q[LEN_W-8:0], b[6:0] & LEN_GRP_MASK[6:0]};
  assign len_done  = ((b & LEN_MORE_BIT) == 8'h00) ||
                     (grp_inc >= GRP_W'(MAX_LENGTH_GROUPS));

  always_comb begin
    phase_s   = phase_q;
    skip_s    = skip_q;
    acc_s     = acc_q;
    grp_s     = grp_q;
    tag_s     = tag_q;
    rem_s     = rem_q;
    seen_s    = seen_q;
    pay_valid = 1'b0;
    case (phase_q)
      PH_HDR: begin
        skip_s = skip_dec;
        if (skip_dec == '0) phase_s = PH_TAG1;
      end
      PH_TAG1, PH_TAG2, PH_TAG3: begin
        tag_s = b;
        acc_s = '0;
        grp_s = '0;
        if (phase_q == PH_TAG1) begin
          phase_s = PH_LEN1;
        end else if (phase_q == PH_TAG2) begin
          phase_s = PH_LEN2;
        end else begin
          phase_s = PH_LEN3;
        end
      end
      PH_LEN1: begin
        acc_s = acc_shift;
        grp_s = grp_inc;
        if (len_done) begin
          phase_s = PH_ID;
          skip_s  = ID_SKIP;
        end
      end
      PH_ID: begin
        skip_s = skip_dec;
        if (skip_dec == '0) phase_s = (tag_q == TAG_ES_DESC) ? PH_PRIO : PH_TAG2;
      end
      PH_PRIO: begin
        phase_s = PH_TAG2;
      end
      PH_LEN2: begin
        acc_s = acc_shift;
        grp_s = grp_inc;
        if (len_done) begin
          if (tag_q == TAG_DEC_CFG) begin
            phase_s = PH_CFG;
            skip_s  = CFG_SKIP;
          end else begin
            phase_s = PH_DONE;
          end
        end
      end
      PH_CFG: begin
        skip_s = skip_dec;
        if (skip_dec == '0) phase_s = PH_TAG3;
      end
      PH_LEN3: begin
        acc_s = acc_shift;
        grp_s = grp_inc;
        if (len_done) begin
          if (tag_q == TAG_DEC_SPEC) begin
            rem_s = acc_shift;
            if (acc_shift == '0) begin
              seen_s  = 1'b1;
              phase_s = PH_DONE;
            end else begin
              phase_s = PH_PAY;
            end
          end else begin
            phase_s = PH_DONE;
          end
        end
      end
      PH_PAY: begin
        pay_valid = 1'b1;
        rem_s     = rem_dec;
        if (rem_dec == '0) begin
          seen_s  = 1'b1;
          phase_s = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pay_item.item_kind      = KIND_PAYLOAD;
    pay_item.payload_byte   = b;
    pay_item.status_code    = ST_FOUND;
    pay_item.payload_length = acc_q;
    pay_item.run_last       = 1'b0;

    stat_item.item_kind    = KIND_STATUS;
    stat_item.payload_byte = 8'h00;
    stat_item.run_last     = 1'b1;
    if (seen_s) begin
      stat_item.status_code    = ST_FOUND;
      stat_item.payload_length = acc_s;
    end else if (phase_s == PH_PAY) begin
      stat_item.status_code    = ST_TRUNCATED;
      stat_item.payload_length = acc_s;
    end else if ((phase_s == PH_LEN3) && (tag_s == TAG_DEC_SPEC)) begin
      stat_item.payload_length = {acc_s[LEN_W-8:0], 7'b0};
      stat_item.status_code    = (acc_s[LEN_W-8:0] == '0) ? ST_FOUND : ST_TRUNCATED;
    end else begin
      stat_item.status_code    = ST_NONE;
      stat_item.payload_length = '0;
    end
  end

  always_comb begin
    if (s_axis_tlast_i) begin
      phase_d = PH_HDR;
      skip_d  = HDR_SKIP;
      acc_d   = '0;
      grp_d   = '0;
      tag_d   = '0;
      rem_d   = '0;
      seen_d  = 1'b0;
    end else begin
      phase_d = phase_s;
      skip_d  = skip_s;
      acc_d   = acc_s;
      grp_d   = grp_s;
      tag_d   = tag_s;
      rem_d   = rem_s;
      seen_d  = seen_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      skip_q  <= HDR_SKIP;
      acc_q   <= '0;
      grp_q   <= '0;
      tag_q   <= '0;
      rem_q   <= '0;
      seen_q  <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      acc_q   <= acc_d;
      grp_q   <= grp_d;
      tag_q   <= tag_d;
      rem_q   <= rem_d;
      seen_q  <= seen_d;
    end
  end

  always_comb begin
    if (!in_acc) begin
      push.cnt = 2'd0;
    end else begin
      push.cnt = 2'(pay_valid) + 2'(s_axis_tlast_i);
    end
    push.item_a = pay_valid ? pay_item : stat_item;
    push.item_b = stat_item;
  end

  esds_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_ready_i (m_axis_tready_i),
    .valid_o     (m_axis_tvalid_o),
    .item_o      (out_item),
    .room_o      (room)
  );

  assign s_axis_tready_o = room;
  assign m_axis_tdata_o  = {2'b00, out_item.payload_length, out_item.status_code,
                            out_item.payload_byte};
  assign m_axis_tuser_o  = out_item.item_kind;
  assign m_axis_tlast_o  = out_item.run_last;

  `ASSERT_AT(a_reset_after_record, clk_i, rst_ni,
    (in_acc && s_axis_tlast_i) |=> (phase_q == PH_HDR && skip_q == HDR_SKIP && !seen_q))
  `ASSERT_NEVER(a_pay_rem_nonzero, clk_i, rst_ni, (phase_q == PH_PAY) && (rem_q == '0))
  `ASSERT_NEVER(a_stall_without_output, clk_i, rst_ni, !s_axis_tready_o && !m_axis_tvalid_o)

endmodule
